// ----- rtl/servo_command_decoder_core_defines.svh -----
// ---------------------------------------------------------------------------
// Servo command decoder assertion macros
// Shared property shapes for the decoder checks; clk and rst_n come from the
// scope that uses them.
// ---------------------------------------------------------------------------
`ifndef SERVO_COMMAND_DECODER_CORE_DEFINES_SVH
`define SERVO_COMMAND_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define SCD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("servo decoder check failed");

// Next-cycle implication, checked out of reset
`define SCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("servo decoder check failed");

`endif

// ----- rtl/scd_pkg.sv -----
// ---------------------------------------------------------------------------
// Servo command decoder package
// Frame phase codes, command characters, preset duties and shared types.
// ---------------------------------------------------------------------------
package scd_pkg;

    // Frame phase codes
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HUND = 2'd1;
    localparam logic [1:0] PH_TENS = 2'd2;
    localparam logic [1:0] PH_UNIT = 2'd3;

    // Operation codes of an input beat
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Command characters
    localparam logic [7:0] CH_TILT   = 8'h74; // t
    localparam logic [7:0] CH_PAN    = 8'h70; // p
    localparam logic [7:0] CH_T_300  = 8'h61; // a
    localparam logic [7:0] CH_T_310  = 8'h73; // s
    localparam logic [7:0] CH_T_750  = 8'h64; // d
    localparam logic [7:0] CH_T_1350 = 8'h66; // f
    localparam logic [7:0] CH_T_1370 = 8'h67; // g
    localparam logic [7:0] CH_P_290  = 8'h7a; // z
    localparam logic [7:0] CH_P_300  = 8'h78; // x
    localparam logic [7:0] CH_P_750  = 8'h63; // c
    localparam logic [7:0] CH_P_1330 = 8'h76; // v
    localparam logic [7:0] CH_P_1345 = 8'h62; // b
    localparam logic [8:0] ASCII_ZERO = 9'd48;

    // Preset and reset duties
    localparam logic [10:0] DUTY_290  = 11'd290;
    localparam logic [10:0] DUTY_300  = 11'd300;
    localparam logic [10:0] DUTY_310  = 11'd310;
    localparam logic [10:0] DUTY_750  = 11'd750;
    localparam logic [10:0] DUTY_1330 = 11'd1330;
    localparam logic [10:0] DUTY_1345 = 11'd1345;
    localparam logic [10:0] DUTY_1350 = 11'd1350;
    localparam logic [10:0] DUTY_1370 = 11'd1370;

    localparam logic [10:0] LOW_RESET  = 11'd500;
    localparam logic [10:0] HIGH_RESET = 11'd1000;

    // LED toggle masks
    localparam logic [7:0] LED_TILT = 8'h01;
    localparam logic [7:0] LED_PAN  = 8'h02;
    localparam logic [7:0] LED_TICK = 8'h80;

    // Register indexes
    localparam logic REG_LOW  = 1'b0;
    localparam logic REG_HIGH = 1'b1;

    typedef struct packed {
        logic [10:0] low;
        logic [10:0] high;
    } cfg_t;

    typedef struct packed {
        logic [10:0] tilt_duty;
        logic [10:0] pan_duty;
        logic [7:0]  led_pattern;
        logic        position_applied;
    } result_t;

endpackage

// ----- rtl/scd_cmd_if.sv -----
// ---------------------------------------------------------------------------
// Servo command channel
// Valid/ready channel carrying one received byte or one timer tick a beat.
// ---------------------------------------------------------------------------
interface scd_cmd_if;

    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink   (input valid, input operation, input rx_byte, output ready);

endinterface

// ----- rtl/scd_rsp_if.sv -----
// ---------------------------------------------------------------------------
// Servo result channel
// Valid/ready channel carrying the duties and LED state after each item.
// ---------------------------------------------------------------------------
interface scd_rsp_if;

    logic        valid;
    logic        ready;
    logic [10:0] tilt_duty;
    logic [10:0] pan_duty;
    logic [7:0]  led_pattern;
    logic        position_applied;

    modport source (output valid, output tilt_duty, output pan_duty,
                    output led_pattern, output position_applied, input ready);
    modport sink   (input valid, input tilt_duty, input pan_duty,
                    input led_pattern, input position_applied, output ready);

endinterface

// ----- rtl/scd_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// Servo decoder configuration registers
// APB write/read of the exclusive low and high position bounds.
// ---------------------------------------------------------------------------
module scd_cfg_regs
    import scd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [10:0] low_reg;
    logic [10:0] high_reg;
    logic [10:0] low_next;
    logic [10:0] high_next;
    logic        wr_en;
    logic        reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    // Pick up a write to the addressed bound
    always_comb
    begin
        low_next  = low_reg;
        high_next = high_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_LOW:  low_next  = pwdata[10:0];
                REG_HIGH: high_next = pwdata[10:0];
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= LOW_RESET;
            high_reg <= HIGH_RESET;
        end
        else
        begin
            low_reg  <= low_next;
            high_reg <= high_next;
        end
    end

    // Read back the addressed bound
    always_comb
    begin
        case (reg_sel)
            REG_LOW:  prdata = {21'd0, low_reg};
            REG_HIGH: prdata = {21'd0, high_reg};
            default:  prdata = 32'd0;
        endcase
    end

    assign cfg.low  = low_reg;
    assign cfg.high = high_reg;

endmodule

// ----- rtl/scd_decode.sv -----
// ---------------------------------------------------------------------------
// Servo command decode step
// Frame state and setpoints; one item a cycle, when step is high, to the result.
// ---------------------------------------------------------------------------
module scd_decode
    import scd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic       operation,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    output result_t    res
);

`include "servo_command_decoder_core_defines.svh"

    logic [1:0]         phase_reg, phase_next;
    logic               is_tilt_reg, is_tilt_next;
    logic signed [15:0] partial_reg, partial_next;
    logic [10:0]        tilt_reg, tilt_next;
    logic [10:0]        pan_reg, pan_next;
    logic [7:0]         led_reg, led_next;
    logic               applied;

    logic signed [8:0]  digit;
    logic signed [16:0] hund;
    logic signed [16:0] tens;
    logic signed [16:0] val;
    logic               in_range;

    // Digit arithmetic: byte minus '0', no digit check
    assign digit    = $signed({1'b0, rx_byte} - ASCII_ZERO);
    assign hund     = 17'(digit) * 17'sd100;
    assign tens     = 17'(digit) * 17'sd10;
    assign val      = 17'(partial_reg) + 17'(digit);
    assign in_range = (val > $signed({6'd0, cfg.low})) && (val < $signed({6'd0, cfg.high}));

    // Advance the frame state for one item
    always_comb
    begin
        phase_next   = phase_reg;
        is_tilt_next = is_tilt_reg;
        partial_next = partial_reg;
        tilt_next    = tilt_reg;
        pan_next     = pan_reg;
        led_next     = led_reg;
        applied      = 1'b0;
        if (operation == OP_TICK)
        begin
            led_next = led_reg ^ LED_TICK;
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    case (rx_byte)
                        CH_TILT:
                        begin
                            is_tilt_next = 1'b1;
                            phase_next   = PH_HUND;
                        end
                        CH_PAN:
                        begin
                            is_tilt_next = 1'b0;
                            phase_next   = PH_HUND;
                        end
                        CH_T_300:  tilt_next = DUTY_300;
                        CH_T_310:  tilt_next = DUTY_310;
                        CH_T_750:  tilt_next = DUTY_750;
                        CH_T_1350: tilt_next = DUTY_1350;
                        CH_T_1370: tilt_next = DUTY_1370;
                        CH_P_290:  pan_next  = DUTY_290;
                        CH_P_300:  pan_next  = DUTY_300;
                        CH_P_750:  pan_next  = DUTY_750;
                        CH_P_1330: pan_next  = DUTY_1330;
                        CH_P_1345: pan_next  = DUTY_1345;
                        default:   ;
                    endcase
                end
                PH_HUND:
                begin
                    partial_next = hund[15:0];
                    phase_next   = PH_TENS;
                end
                PH_TENS:
                begin
                    partial_next = partial_reg + tens[15:0];
                    phase_next   = PH_UNIT;
                end
                PH_UNIT:
                begin
                    partial_next = val[15:0];
                    phase_next   = PH_IDLE;
                    if (in_range)
                    begin
                        applied = 1'b1;
                        if (is_tilt_reg)
                        begin
                            tilt_next = val[10:0];
                            led_next  = led_reg ^ LED_TILT;
                        end
                        else
                        begin
                            pan_next = val[10:0];
                            led_next = led_reg ^ LED_PAN;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Commit state when the item moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            is_tilt_reg <= 1'b0;
            partial_reg <= 16'sd0;
            tilt_reg    <= DUTY_750;
            pan_reg     <= DUTY_750;
            led_reg     <= 8'd0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            is_tilt_reg <= is_tilt_next;
            partial_reg <= partial_next;
            tilt_reg    <= tilt_next;
            pan_reg     <= pan_next;
            led_reg     <= led_next;
        end
    end

    assign res.tilt_duty        = tilt_next;
    assign res.pan_duty         = pan_next;
    assign res.led_pattern      = led_next;
    assign res.position_applied = applied;

    // A completed accepted frame only ever comes from the units digit of a byte
    `SCD_ASSERT_NOW(a_applied_on_unit, applied, (phase_reg == PH_UNIT) && (operation == OP_BYTE))
    // The units digit always closes the frame
    `SCD_ASSERT_NEXT(a_unit_closes, step && (operation == OP_BYTE) && (phase_reg == PH_UNIT),
                     phase_reg == PH_IDLE)
    // A tick leaves frame and setpoints alone
    `SCD_ASSERT_NEXT(a_tick_keeps, step && (operation == OP_TICK),
                     $stable(phase_reg) && $stable(tilt_reg) && $stable(pan_reg))

endmodule

// ----- rtl/servo_command_decoder_core.sv -----
// ---------------------------------------------------------------------------
// Servo command decoder core
// Serial command bytes and timer ticks in, tilt/pan duties and LEDs out.
// ---------------------------------------------------------------------------
// Each beat on cmd is either a received byte or a PWM timer tick, and gives
// exactly one beat on rsp with the tilt and pan duties and LED pattern after
// that item. A new item is taken every cycle while rsp keeps ready high.
// rsp.valid rises once the result register is loaded: the item sits in the
// input register while the frame decode and bound compare run, and moves
// into the result register as soon as that register is free.
// While a result waits on rsp, cmd takes one more item into the input
// register and then holds ready low until the result moves on.
// The position bounds sit at APB offsets 0x0 (low) and 0x4 (high) and are
// both exclusive; write them only while no item is in flight.
module servo_command_decoder_core
    import scd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    scd_cmd_if.sink     cmd,
    scd_rsp_if.source   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "servo_command_decoder_core_defines.svh"

    cfg_t       cfg;
    result_t    res_next;
    result_t    res_reg;
    logic       in_valid_reg, in_valid_next;
    logic       in_op_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg, out_valid_next;
    logic       step;
    logic       cmd_take;

    scd_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    scd_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .operation (in_op_reg),
        .rx_byte   (in_byte_reg),
        .cfg       (cfg),
        .res       (res_next)
    );

    // Move the held item into the result register when it is free
    assign step      = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready = !in_valid_reg || step;
    assign cmd_take  = cmd.valid && cmd.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (cmd_take)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input beat and the finished result
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            in_op_reg   <= cmd.operation;
            in_byte_reg <= cmd.rx_byte;
        end
        if (step)
            res_reg <= res_next;
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.tilt_duty        = res_reg.tilt_duty;
    assign rsp.pan_duty         = res_reg.pan_duty;
    assign rsp.led_pattern      = res_reg.led_pattern;
    assign rsp.position_applied = res_reg.position_applied;

    // A held item is never dropped without moving to the result register
    `SCD_ASSERT_NEXT(a_item_held, in_valid_reg && !step, in_valid_reg)
    // A stalled result is never overwritten
    `SCD_ASSERT_NOW(a_no_overwrite, step, !out_valid_reg || rsp.ready)
    // Every step leaves a result waiting
    `SCD_ASSERT_NEXT(a_step_fills, step, out_valid_reg)

endmodule
